/* hdl/tfs_pkg.sv */
// Shared constants, register codes and interface structs for the timed fill sequencer.
package tfs_pkg;

    // Sizing of the wait queue and the data fields.
    localparam int QUEUE_DEPTH = 16;
    localparam int TANK_BITS   = 4;
    localparam int SAMPLE_BITS = 12;
    localparam int COUNT_BITS  = $clog2(QUEUE_DEPTH + 1);
    localparam int TICK_BITS   = 16;
    localparam int DUTY_BITS   = 8;
    localparam int FAULT_BITS  = 2;

    // Saturation value of the tick counters.
    localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

    // Configuration port geometry: five registers at byte addresses 4*i.
    localparam int NUM_REGS  = 5;
    localparam int ADDR_BITS = $clog2(NUM_REGS * 4);
    localparam int IDX_BITS  = ADDR_BITS - 2;
    localparam int APB_BITS  = 32;

    // Register reset values.
    localparam logic [TICK_BITS-1:0]   FILL_LEN_RST      = TICK_BITS'(15000);
    localparam logic [TICK_BITS-1:0]   GRACE_TIME_RST    = TICK_BITS'(2000);
    localparam logic [SAMPLE_BITS-1:0] FLOW_THRESH_RST   = SAMPLE_BITS'(100);
    localparam logic [TICK_BITS-1:0]   BLINK_HALF_RST    = TICK_BITS'(500);
    localparam logic [DUTY_BITS-1:0]   PUMP_DUTY_RST     = DUTY_BITS'(128);

    // Input beat layout, lowest bits first.
    localparam int IN_TANK_LSB   = 0;
    localparam int IN_WATER_LSB  = IN_TANK_LSB + TANK_BITS;
    localparam int IN_CHEM_LSB   = IN_WATER_LSB + SAMPLE_BITS;
    localparam int IN_SWITCH_LSB = IN_CHEM_LSB + SAMPLE_BITS;
    localparam int IN_FIELD_BITS = IN_SWITCH_LSB + 1;
    localparam int IN_DATA_BITS  = ((IN_FIELD_BITS + 7) / 8) * 8;

    // Output beat layout, lowest bits first.
    localparam int OUT_VALVE_LSB   = 0;
    localparam int OUT_PUMP_LSB    = OUT_VALVE_LSB + 1;
    localparam int OUT_YELLOW_LSB  = OUT_PUMP_LSB + DUTY_BITS;
    localparam int OUT_RED_LSB     = OUT_YELLOW_LSB + 1;
    localparam int OUT_FILLING_LSB = OUT_RED_LSB + 1;
    localparam int OUT_TANK_LSB    = OUT_FILLING_LSB + 1;
    localparam int OUT_COUNT_LSB   = OUT_TANK_LSB + TANK_BITS;
    localparam int OUT_HALTED_LSB  = OUT_COUNT_LSB + COUNT_BITS;
    localparam int OUT_FAULT_LSB   = OUT_HALTED_LSB + 1;
    localparam int OUT_FIELD_BITS  = OUT_FAULT_LSB + FAULT_BITS;
    localparam int OUT_DATA_BITS   = ((OUT_FIELD_BITS + 7) / 8) * 8;

    // Register indexes on the configuration port.
    typedef enum logic [IDX_BITS-1:0] {
        REG_FILL_LEN      = IDX_BITS'(0),
        REG_GRACE_TIME    = IDX_BITS'(1),
        REG_FLOW_THRESH   = IDX_BITS'(2),
        REG_BLINK_HALF    = IDX_BITS'(3),
        REG_PUMP_DUTY     = IDX_BITS'(4)
    } reg_idx_t;

    // Fault codes reported while halted.
    typedef enum logic [FAULT_BITS-1:0] {
        FAULT_NONE  = 2'd0,
        FAULT_WATER = 2'd1,
        FAULT_LINE  = 2'd2
    } fault_t;

    // Configuration register set.
    typedef struct packed {
        logic [TICK_BITS-1:0]   fill_len;
        logic [TICK_BITS-1:0]   grace_time;
        logic [SAMPLE_BITS-1:0] flow_threshold;
        logic [TICK_BITS-1:0]   blink_half_period;
        logic [DUTY_BITS-1:0]   pump_duty;
    } cfg_t;

    // Commands from the controller to the queue.
    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic [TANK_BITS-1:0] tank;
    } q_cmd_t;

    // Status of the queue seen by the controller and the output stage.
    typedef struct packed {
        logic [TANK_BITS-1:0]  head;
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] count_next;
    } q_stat_t;

    // Controller view of the result beat, except the waiting count.
    typedef struct packed {
        logic                 valve_open;
        logic [DUTY_BITS-1:0] pump_drive;
        logic                 yellow_alarm;
        logic                 red_alarm;
        logic                 filling;
        logic [TANK_BITS-1:0] current_tank;
        logic                 halted;
        fault_t               fault_code;
    } ctrl_res_t;

endpackage

/* hdl/timed_fill_sequencer_core.sv */
// A result beat is registered and appears on the master side in the cycle after its input beat is accepted.
// Throughput: one input beat per cycle while not stalled; the output register is refilled in the cycle it drains.
// Each beat passes the queue cell compares and the fill controller in the cycle it is accepted.
// Reset (rst_n low, asynchronous) empties the queue, clears fill, halt and alarm state,
// and restores every configuration register to its default. Queue cells hold no reset value.
module timed_fill_sequencer_core
    import tfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    // Input beats.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // tank_id, water_flow, chem_flow, tank_switch
    input  logic                     s_tuser,   // kind
    // Result beats.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,   // valve_open, pump_drive, yellow_alarm,
                                                // red_alarm, filling, current_tank,
                                                // waiting_count, halted, fault_code
    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_BITS-1:0]     paddr,
    input  logic [APB_BITS-1:0]      pwdata,
    output logic [APB_BITS-1:0]      prdata,
    output logic                     pready
);

    cfg_t                     cfg_reg;
    logic                     cfg_wr;
    logic [IDX_BITS-1:0]      reg_idx;
    logic                     accept;
    q_cmd_t                   q_cmd;
    q_stat_t                  q_stat;
    ctrl_res_t                res;
    logic                     m_tvalid_reg;
    logic [OUT_DATA_BITS-1:0] m_tdata_reg;
    logic [OUT_DATA_BITS-1:0] m_tdata_next;

    // Configuration registers.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign reg_idx = paddr[ADDR_BITS-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.fill_len          <= FILL_LEN_RST;
            cfg_reg.grace_time        <= GRACE_TIME_RST;
            cfg_reg.flow_threshold    <= FLOW_THRESH_RST;
            cfg_reg.blink_half_period <= BLINK_HALF_RST;
            cfg_reg.pump_duty         <= PUMP_DUTY_RST;
        end
        else if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_FILL_LEN:      cfg_reg.fill_len          <= pwdata[TICK_BITS-1:0];
                REG_GRACE_TIME:    cfg_reg.grace_time        <= pwdata[TICK_BITS-1:0];
                REG_FLOW_THRESH:   cfg_reg.flow_threshold    <= pwdata[SAMPLE_BITS-1:0];
                REG_BLINK_HALF:    cfg_reg.blink_half_period <= pwdata[TICK_BITS-1:0];
                REG_PUMP_DUTY:     cfg_reg.pump_duty         <= pwdata[DUTY_BITS-1:0];
                default:           ;
            endcase
        end
    end

    // Register read back.
    always_comb
    begin
        unique case (reg_idx)
            REG_FILL_LEN:      prdata = APB_BITS'(cfg_reg.fill_len);
            REG_GRACE_TIME:    prdata = APB_BITS'(cfg_reg.grace_time);
            REG_FLOW_THRESH:   prdata = APB_BITS'(cfg_reg.flow_threshold);
            REG_BLINK_HALF:    prdata = APB_BITS'(cfg_reg.blink_half_period);
            REG_PUMP_DUTY:     prdata = APB_BITS'(cfg_reg.pump_duty);
            default:           prdata = '0;
        endcase
    end

    // A new beat is taken whenever the output register is empty or draining.
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    tfs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .kind        (s_tuser),
        .tank_id     (s_tdata[IN_TANK_LSB +: TANK_BITS]),
        .water_flow  (s_tdata[IN_WATER_LSB +: SAMPLE_BITS]),
        .chem_flow   (s_tdata[IN_CHEM_LSB +: SAMPLE_BITS]),
        .tank_switch (s_tdata[IN_SWITCH_LSB]),
        .cfg         (cfg_reg),
        .q_stat      (q_stat),
        .q_cmd       (q_cmd),
        .res         (res)
    );

    tfs_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (q_cmd),
        .stat  (q_stat)
    );

    // Pack the result beat, first field in the lowest bits.
    assign m_tdata_next = OUT_DATA_BITS'({res.fault_code, res.halted, q_stat.count_next,
                                          res.current_tank, res.filling, res.red_alarm,
                                          res.yellow_alarm, res.pump_drive, res.valve_open});

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

/* hdl/tfs_cell.sv */
// One queue cell: holds a waiting tank, takes its neighbor's entry on a pop.
module tfs_cell
    import tfs_pkg::*;
(
    input  logic                 clk,
    input  logic                 load,
    input  logic                 shift,
    input  logic [TANK_BITS-1:0] new_tank,
    input  logic [TANK_BITS-1:0] next_tank,
    input  logic [TANK_BITS-1:0] probe_tank,
    input  logic                 occupied,
    output logic [TANK_BITS-1:0] entry,
    output logic                 hit
);

    logic [TANK_BITS-1:0] entry_reg;

    // A push lands in the first free cell; a pop moves every entry one cell to the head.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            entry_reg <= new_tank;
        end
        else if (shift)
        begin
            entry_reg <= next_tank;
        end
    end

    // Duplicate detection for an incoming request.
    assign hit   = occupied && (entry_reg == probe_tank);
    assign entry = entry_reg;

endmodule

/* hdl/tfs_queue.sv */
// Wait queue built as a chain of cells with a fill count.
module tfs_queue
    import tfs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  q_cmd_t  cmd,
    output q_stat_t stat
);

    logic [COUNT_BITS-1:0]  count_reg;
    logic [COUNT_BITS-1:0]  count_next;
    logic [TANK_BITS-1:0]   entry [QUEUE_DEPTH];
    logic [QUEUE_DEPTH-1:0] hit;
    logic                   push_ok;

    // A request is taken only if the tank is not waiting already and a cell is free.
    assign push_ok = cmd.push && !(|hit) && (count_reg < COUNT_BITS'(QUEUE_DEPTH));

    // Row of cells; the last one refills from itself since it is never occupied after a pop.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic [TANK_BITS-1:0] neighbor;

        if (i == QUEUE_DEPTH - 1)
        begin : g_tail
            assign neighbor = entry[i];
        end
        else
        begin : g_body
            assign neighbor = entry[i + 1];
        end

        tfs_cell u_cell (
            .clk        (clk),
            .load       (push_ok && (count_reg == COUNT_BITS'(i))),
            .shift      (cmd.pop),
            .new_tank   (cmd.tank),
            .next_tank  (neighbor),
            .probe_tank (cmd.tank),
            .occupied   (count_reg > COUNT_BITS'(i)),
            .entry      (entry[i]),
            .hit        (hit[i])
        );
    end

    // Fill count; push and pop never come in the same beat.
    always_comb
    begin
        count_next = count_reg;
        if (push_ok)
        begin
            count_next = count_reg + COUNT_BITS'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - COUNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stat.head       = entry[0];
    assign stat.count      = count_reg;
    assign stat.count_next = count_next;

endmodule

/* hdl/tfs_ctrl.sv */
// Fill and halt controller: fill timer, flow checks, fault latch and alarm blinker.
module tfs_ctrl
    import tfs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   accept,
    input  logic                   kind,
    input  logic [TANK_BITS-1:0]   tank_id,
    input  logic [SAMPLE_BITS-1:0] water_flow,
    input  logic [SAMPLE_BITS-1:0] chem_flow,
    input  logic                   tank_switch,
    input  cfg_t                   cfg,
    input  q_stat_t                q_stat,
    output q_cmd_t                 q_cmd,
    output ctrl_res_t              res
);

    logic                 fill_active_reg, fill_active_next;
    logic [TANK_BITS-1:0] tank_reg, tank_next;
    logic [TICK_BITS-1:0] fill_ticks_reg, fill_ticks_next;
    logic                 halt_reg, halt_next;
    fault_t               fault_reg, fault_next;
    logic [TICK_BITS-1:0] blink_ticks_reg, blink_ticks_next;
    logic                 blink_reg, blink_next;
    logic                 yellow_reg, yellow_next;
    logic                 pop_req;
    logic                 run;

    // A request is pushed unless it names no tank or the tank being filled.
    assign q_cmd.tank = tank_id;
    assign q_cmd.push = accept && kind && (tank_id != '0)
                        && !(fill_active_reg && (tank_id == tank_reg));
    assign q_cmd.pop  = pop_req;

    // Tick handling: blink while halted, otherwise time the fill and check flow.
    always_comb
    begin
        fill_active_next = fill_active_reg;
        tank_next        = tank_reg;
        fill_ticks_next  = fill_ticks_reg;
        halt_next        = halt_reg;
        fault_next       = fault_reg;
        blink_ticks_next = blink_ticks_reg;
        blink_next       = blink_reg;
        yellow_next      = yellow_reg;
        pop_req          = 1'b0;

        if (accept && !kind)
        begin
            if (halt_reg)
            begin
                if (blink_ticks_reg != TICK_MAX)
                begin
                    blink_ticks_next = blink_ticks_reg + TICK_BITS'(1);
                end
                if (blink_ticks_next >= cfg.blink_half_period)
                begin
                    blink_next       = !blink_reg;
                    blink_ticks_next = '0;
                end
            end
            else
            begin
                yellow_next = tank_switch;

                if (fill_active_reg && (fill_ticks_reg != TICK_MAX))
                begin
                    fill_ticks_next = fill_ticks_reg + TICK_BITS'(1);
                end

                // Flow checks start once the grace time is over.
                if (fill_active_reg && (fill_ticks_next > cfg.grace_time)
                    && ((water_flow < cfg.flow_threshold) || (chem_flow < cfg.flow_threshold)))
                begin
                    halt_next        = 1'b1;
                    fault_next       = (water_flow < cfg.flow_threshold) ? FAULT_WATER
                                                                         : FAULT_LINE;
                    fill_active_next = 1'b0;
                    tank_next        = '0;
                    fill_ticks_next  = '0;
                    blink_ticks_next = '0;
                    blink_next       = 1'b1;
                end
                else
                begin
                    // Start the next waiting fill when idle.
                    if (!fill_active_reg && (q_stat.count != '0))
                    begin
                        pop_req          = 1'b1;
                        tank_next        = q_stat.head;
                        fill_active_next = 1'b1;
                        fill_ticks_next  = '0;
                    end
                    // End the fill once its duration has elapsed.
                    if (fill_active_next && (fill_ticks_next >= cfg.fill_len))
                    begin
                        fill_active_next = 1'b0;
                        tank_next        = '0;
                        fill_ticks_next  = '0;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_active_reg <= 1'b0;
            tank_reg        <= '0;
            fill_ticks_reg  <= '0;
            halt_reg        <= 1'b0;
            fault_reg       <= FAULT_NONE;
            blink_ticks_reg <= '0;
            blink_reg       <= 1'b0;
            yellow_reg      <= 1'b0;
        end
        else
        begin
            fill_active_reg <= fill_active_next;
            tank_reg        <= tank_next;
            fill_ticks_reg  <= fill_ticks_next;
            halt_reg        <= halt_next;
            fault_reg       <= fault_next;
            blink_ticks_reg <= blink_ticks_next;
            blink_reg       <= blink_next;
            yellow_reg      <= yellow_next;
        end
    end

    // Result fields show the state after the beat.
    assign run = fill_active_next && !halt_next;

    assign res.valve_open   = run;
    assign res.pump_drive   = run ? cfg.pump_duty : '0;
    assign res.yellow_alarm = yellow_next;
    assign res.red_alarm    = halt_next && blink_next;
    assign res.filling      = run;
    assign res.current_tank = tank_next;
    assign res.halted       = halt_next;
    assign res.fault_code   = fault_next;

endmodule

/* hdl/tfs_checker.sv */
// Port-level checker for the timed fill sequencer, bound to the top level.
module tfs_checker
    import tfs_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic [IN_DATA_BITS-1:0]  s_tdata,
    input logic                     s_tuser,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [OUT_DATA_BITS-1:0] m_tdata,
    input logic                     psel,
    input logic                     penable,
    input logic                     pwrite,
    input logic [ADDR_BITS-1:0]     paddr,
    input logic [APB_BITS-1:0]      pwdata,
    input logic [APB_BITS-1:0]      prdata,
    input logic                     pready
);

    // A stalled result beat holds its value.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    // A result beat only appears after an input beat was taken.
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready))
        else $error("result beat without an input beat");

    // Valve, pump and tank show nothing unless a fill is running.
    a_idle_outputs: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[OUT_FILLING_LSB] |->
            !m_tdata[OUT_VALVE_LSB] && (m_tdata[OUT_PUMP_LSB +: DUTY_BITS] == '0)
            && (m_tdata[OUT_TANK_LSB +: TANK_BITS] == '0))
        else $error("drive active outside a fill");

    // A fault code is reported exactly when halted, and a halt stops the fill.
    a_fault_halt: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |->
            (m_tdata[OUT_HALTED_LSB] == (m_tdata[OUT_FAULT_LSB +: FAULT_BITS] != FAULT_NONE))
            && (m_tdata[OUT_FAULT_LSB +: FAULT_BITS] <= FAULT_LINE)
            && !(m_tdata[OUT_HALTED_LSB] && m_tdata[OUT_FILLING_LSB]))
        else $error("fault code and halt flag disagree");

    // The waiting count never exceeds the queue depth.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[OUT_COUNT_LSB +: COUNT_BITS] <= COUNT_BITS'(QUEUE_DEPTH))
        else $error("waiting count beyond queue depth");

endmodule

bind timed_fill_sequencer_core tfs_checker u_tfs_checker (.*);

/* test/tfs_fill_checker.sv */
`timescale 1ns / 1ps
// Checker that predicts each result beat of the timed fill sequencer and compares it.
module tfs_fill_checker
    import tfs_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,   // tank_id, water_flow, chem_flow, tank_switch
    input  logic                     s_tuser,   // kind
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    input  logic [OUT_DATA_BITS-1:0] m_tdata,   // valve_open, pump_drive, yellow_alarm,
                                                // red_alarm, filling, current_tank,
                                                // waiting_count, halted, fault_code
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [ADDR_BITS-1:0]     paddr,
    input  logic [APB_BITS-1:0]      pwdata,
    input  logic                     pready,
    output int                       error_count,
    output int                       pending_count
);

    // Status fields carried by one result beat.
    typedef struct {
        logic                  valve_open;
        logic [DUTY_BITS-1:0]  pump_drive;
        logic                  yellow_alarm;
        logic                  red_alarm;
        logic                  filling;
        logic [TANK_BITS-1:0]  current_tank;
        logic [COUNT_BITS-1:0] waiting_count;
        logic                  halted;
        fault_t                fault_code;
    } fill_status_t;

    // Shadow copy of the configuration registers.
    logic [TICK_BITS-1:0]   dur_cfg;
    logic [TICK_BITS-1:0]   grace_cfg;
    logic [SAMPLE_BITS-1:0] thr_cfg;
    logic [TICK_BITS-1:0]   blink_cfg;
    logic [DUTY_BITS-1:0]   duty_cfg;

    // Predicted sequencer state.
    logic [TANK_BITS-1:0]   waitlist [$];
    logic                   running;
    logic [TANK_BITS-1:0]   tank_now;
    logic [TICK_BITS-1:0]   elapsed;
    logic                   halt_on;
    fault_t                 fault_now;
    logic [TICK_BITS-1:0]   blink_cnt;
    logic                   blink_on;
    logic                   yellow_on;

    // Statuses still owed by the block, oldest first.
    fill_status_t           status_due [$];
    fill_status_t           want;
    fill_status_t           seen;
    int                     mismatches;

    // Fields of the beat being accepted.
    logic [TANK_BITS-1:0]   in_tank;
    logic [SAMPLE_BITS-1:0] in_water;
    logic [SAMPLE_BITS-1:0] in_chem;
    logic                   in_switch;
    logic                   listed;

    // A flow fault aborts the fill and latches the halt with the red lamp lit.
    task automatic latch_fault(input fault_t code);
        halt_on   = 1'b1;
        fault_now = code;
        running   = 1'b0;
        tank_now  = '0;
        elapsed   = '0;
        blink_cnt = '0;
        blink_on  = 1'b1;
    endtask

    task automatic check_field(input string name, input int unsigned exp_val,
                               input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, got %0d", name, exp_val, act_val);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dur_cfg    = FILL_LEN_RST;
            grace_cfg  = GRACE_TIME_RST;
            thr_cfg    = FLOW_THRESH_RST;
            blink_cfg  = BLINK_HALF_RST;
            duty_cfg   = PUMP_DUTY_RST;
            waitlist.delete();
            running    = 1'b0;
            tank_now   = '0;
            elapsed    = '0;
            halt_on    = 1'b0;
            fault_now  = FAULT_NONE;
            blink_cnt  = '0;
            blink_on   = 1'b0;
            yellow_on  = 1'b0;
            status_due.delete();
            mismatches = 0;
            error_count   <= 0;
            pending_count <= 0;
        end
        else
        begin
            // Register writes land on the access cycle; unknown indexes are dropped.
            if (psel && penable && pwrite && pready)
            begin
                case (reg_idx_t'(paddr[ADDR_BITS-1:2]))
                    REG_FILL_LEN:      dur_cfg   = pwdata[TICK_BITS-1:0];
                    REG_GRACE_TIME:    grace_cfg = pwdata[TICK_BITS-1:0];
                    REG_FLOW_THRESH:   thr_cfg   = pwdata[SAMPLE_BITS-1:0];
                    REG_BLINK_HALF:    blink_cfg = pwdata[TICK_BITS-1:0];
                    REG_PUMP_DUTY:     duty_cfg  = pwdata[DUTY_BITS-1:0];
                    default: ;
                endcase
            end

            // Each accepted input beat advances the prediction and owes one status.
            if (s_tvalid && s_tready)
            begin
                in_tank   = s_tdata[IN_TANK_LSB +: TANK_BITS];
                in_water  = s_tdata[IN_WATER_LSB +: SAMPLE_BITS];
                in_chem   = s_tdata[IN_CHEM_LSB +: SAMPLE_BITS];
                in_switch = s_tdata[IN_SWITCH_LSB];
                if (s_tuser)
                begin
                    // A request names a tank; no tank, the tank in fill and waiting tanks
                    // are ignored, and a full queue drops it.
                    listed = 1'b0;
                    foreach (waitlist[i])
                        if (waitlist[i] == in_tank)
                            listed = 1'b1;
                    if (in_tank != '0 && !(running && in_tank == tank_now) && !listed &&
                        waitlist.size() < QUEUE_DEPTH)
                        waitlist.push_back(in_tank);
                end
                else if (halt_on)
                begin
                    // While halted a tick only paces the red lamp.
                    if (blink_cnt != TICK_MAX)
                        blink_cnt++;
                    if (blink_cnt >= blink_cfg)
                    begin
                        blink_on  = !blink_on;
                        blink_cnt = '0;
                    end
                end
                else
                begin
                    yellow_on = in_switch;
                    if (running)
                    begin
                        if (elapsed != TICK_MAX)
                            elapsed++;
                        if (elapsed > grace_cfg)
                        begin
                            if (in_water < thr_cfg)
                                latch_fault(FAULT_WATER);
                            else if (in_chem < thr_cfg)
                                latch_fault(FAULT_LINE);
                        end
                    end
                    // No fill starts or ends on the tick that halts.
                    if (!halt_on)
                    begin
                        if (!running && waitlist.size() > 0)
                        begin
                            tank_now = waitlist.pop_front();
                            running  = 1'b1;
                            elapsed  = '0;
                        end
                        if (running && elapsed >= dur_cfg)
                        begin
                            running  = 1'b0;
                            tank_now = '0;
                            elapsed  = '0;
                        end
                    end
                end
                want.valve_open    = running;
                want.pump_drive    = running ? duty_cfg : '0;
                want.yellow_alarm  = yellow_on;
                want.red_alarm     = halt_on && blink_on;
                want.filling       = running;
                want.current_tank  = tank_now;
                want.waiting_count = COUNT_BITS'(waitlist.size());
                want.halted        = halt_on;
                want.fault_code    = fault_now;
                status_due.push_back(want);
            end

            // Each accepted result beat is matched with the oldest owed status.
            if (m_tvalid && m_tready)
            begin
                if (status_due.size() == 0)
                begin
                    $error("result beat 0x%h arrived with no status owed", m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = status_due.pop_front();
                    seen.valve_open    = m_tdata[OUT_VALVE_LSB];
                    seen.pump_drive    = m_tdata[OUT_PUMP_LSB +: DUTY_BITS];
                    seen.yellow_alarm  = m_tdata[OUT_YELLOW_LSB];
                    seen.red_alarm     = m_tdata[OUT_RED_LSB];
                    seen.filling       = m_tdata[OUT_FILLING_LSB];
                    seen.current_tank  = m_tdata[OUT_TANK_LSB +: TANK_BITS];
                    seen.waiting_count = m_tdata[OUT_COUNT_LSB +: COUNT_BITS];
                    seen.halted        = m_tdata[OUT_HALTED_LSB];
                    seen.fault_code    = fault_t'(m_tdata[OUT_FAULT_LSB +: FAULT_BITS]);
                    check_field("valve_open", want.valve_open, seen.valve_open);
                    check_field("pump_drive", want.pump_drive, seen.pump_drive);
                    check_field("yellow_alarm", want.yellow_alarm, seen.yellow_alarm);
                    check_field("red_alarm", want.red_alarm, seen.red_alarm);
                    check_field("filling", want.filling, seen.filling);
                    check_field("current_tank", want.current_tank, seen.current_tank);
                    check_field("waiting_count", want.waiting_count, seen.waiting_count);
                    check_field("halted", want.halted, seen.halted);
                    check_field("fault_code", want.fault_code, seen.fault_code);
                end
            end
            error_count   <= mismatches;
            pending_count <= status_due.size();
        end
    end

endmodule

/* test/timed_fill_sequencer_core_tb.sv */
`timescale 1ns / 1ps
// Top of the timed fill sequencer testbench: clock, reset, stimulus, sink pacing and verdict.
module timed_fill_sequencer_core_tb;
    import tfs_pkg::*;

    localparam int   CLK_PERIOD      = 10;
    localparam int   RESET_CYCLES    = 10;
    localparam int   LATENCY_CYCLES  = 1;
    localparam int   SIM_LIMIT_NS    = 10_000_000;
    localparam logic KIND_TICK       = 1'b0;
    localparam logic KIND_REQUEST    = 1'b1;
    localparam logic [ADDR_BITS-1:0] UNUSED_REG_ADDR = ADDR_BITS'(NUM_REGS * 4);

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic                     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [ADDR_BITS-1:0]     paddr;
    logic [APB_BITS-1:0]      pwdata;
    logic [APB_BITS-1:0]      prdata;
    logic                     pready;
    int                       error_count;
    int                       pending_count;

    // Sender gaps can be switched off for back-to-back stretches.
    logic                     gaps_on = 1'b1;

    always #(CLK_PERIOD / 2) clk = ~clk;

    timed_fill_sequencer_core DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    tfs_fill_checker fill_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // Idle lengths: mostly none or short, now and then long.
    function automatic int idle_len();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 50)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 4);
        return $urandom_range(15, 60);
    endfunction

    // Flow sample at or above the floor, with rare dips below it when allowed.
    function automatic logic [SAMPLE_BITS-1:0] flow_sample(input int floor_val,
                                                           input logic dips);
        if (floor_val == 0)
            return SAMPLE_BITS'($urandom);
        if (dips && $urandom_range(0, 79) == 0)
            return SAMPLE_BITS'($urandom_range(0, floor_val - 1));
        return SAMPLE_BITS'($urandom_range(floor_val, (1 << SAMPLE_BITS) - 1));
    endfunction

    task automatic send_beat(input logic kind, input logic [TANK_BITS-1:0] tank,
                             input logic [SAMPLE_BITS-1:0] water,
                             input logic [SAMPLE_BITS-1:0] chem, input logic level);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= IN_DATA_BITS'({level, chem, water, tank});
        do
            @(posedge clk);
        while (!s_tready);
        gap = gaps_on ? idle_len() : 0;
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Stop sending and wait until every owed result has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (LATENCY_CYCLES + 2) @(posedge clk);
    endtask

    // Setup cycle, access cycle, then a return to idle on the configuration port.
    task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [APB_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic apply_settings(input logic [APB_BITS-1:0] dur, input logic [APB_BITS-1:0] grace,
                                  input logic [APB_BITS-1:0] thr, input logic [APB_BITS-1:0] blink,
                                  input logic [APB_BITS-1:0] duty);
        write_reg({REG_FILL_LEN, 2'b00}, dur);
        write_reg({REG_GRACE_TIME, 2'b00}, grace);
        write_reg({REG_FLOW_THRESH, 2'b00}, thr);
        write_reg({REG_BLINK_HALF, 2'b00}, blink);
        write_reg({REG_PUMP_DUTY, 2'b00}, duty);
    endtask

    // Random mix of requests and ticks; samples stay at or above the floor except rare dips.
    task automatic random_run(input int count, input int floor_val, input logic dips);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 99) == 0)
                drain();
            if ($urandom_range(0, 99) < 40)
                send_beat(KIND_REQUEST, TANK_BITS'($urandom), SAMPLE_BITS'($urandom),
                          SAMPLE_BITS'($urandom), 1'($urandom));
            else
                send_beat(KIND_TICK, TANK_BITS'($urandom), flow_sample(floor_val, dips),
                          flow_sample(floor_val, dips), 1'($urandom));
        end
        drain();
    endtask

    // Sink pacing: ready stretches of random length, broken by random stalls.
    initial
    begin : sink_pacing
        int run_len;
        int stall;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                  : $urandom_range(1, 12);
            m_tready <= 1'b1;
            repeat (run_len) @(posedge clk);
            stall = idle_len();
            if (stall != 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int thr_floor;
        int pick;
        logic [SAMPLE_BITS-1:0] low_val;
        logic [APB_BITS-1:0] blink_steps [4];
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= KIND_TICK;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed beats under the reset settings: ignored requests, a duplicate,
        // the tank in fill, fields that the kind ignores, and the yellow lamp.
        send_beat(KIND_TICK, 4'd0, 12'hFFF, 12'hFFF, 1'b1);
        send_beat(KIND_REQUEST, 4'd0, 12'd0, 12'd0, 1'b0);
        send_beat(KIND_REQUEST, 4'd15, 12'd0, 12'd0, 1'b0);
        send_beat(KIND_REQUEST, 4'd15, 12'd0, 12'd0, 1'b0);
        send_beat(KIND_REQUEST, 4'd1, 12'd0, 12'd0, 1'b0);
        send_beat(KIND_TICK, 4'd0, 12'd0, 12'd0, 1'b0);
        send_beat(KIND_REQUEST, 4'd15, 12'd0, 12'd0, 1'b0);
        send_beat(KIND_TICK, 4'd0, 12'd0, 12'd0, 1'b1);
        send_beat(KIND_REQUEST, 4'd10, 12'hFFF, 12'hFFF, 1'b1);
        send_beat(KIND_TICK, 4'hF, 12'hFFF, 12'hFFF, 1'b0);
        drain();

        // Zero fill duration and zero threshold: fills end on the tick they start.
        apply_settings(32'hFFFF_0000, '0, 32'hFFFF_F000, '0, 32'hFF);
        write_reg(UNUSED_REG_ADDR, 32'hFFFF_FFFF);
        send_beat(KIND_TICK, 4'd0, 12'd0, 12'd0, 1'b1);
        send_beat(KIND_TICK, 4'd0, 12'd0, 12'd0, 1'b0);
        send_beat(KIND_TICK, 4'd0, 12'hFFF, 12'd0, 1'b1);
        send_beat(KIND_TICK, 4'd0, 12'd0, 12'hFFF, 1'b0);
        drain();

        // Settings that can never fault: the grace time at its maximum or a zero threshold.
        apply_settings(32'd1, 32'hFFFF, 32'hFFF, 32'hFFFF, 32'd0);
        random_run(110, 0, 1'b0);
        apply_settings($urandom_range(1, 8), 32'hFFFF, $urandom, $urandom, $urandom);
        random_run(110, 0, 1'b0);
        apply_settings($urandom_range(2, 12), $urandom_range(0, 4), $urandom & 32'hFFFF_F000,
                       $urandom, $urandom);
        random_run(110, 0, 1'b0);
        apply_settings(32'hFFFF, 32'hFFFF, $urandom, $urandom, $urandom);
        random_run(110, 0, 1'b0);
        apply_settings(32'd0, 32'd0, 32'd0, 32'd1, 32'hFF);
        random_run(110, 0, 1'b0);

        // Flow checked from early in each fill; samples stay above the threshold but for rare dips.
        thr_floor = $urandom_range(64, 3000);
        apply_settings($urandom_range(10, 40), $urandom_range(0, 3), thr_floor,
                       $urandom_range(2, 6), $urandom);
        random_run(100, thr_floor, 1'b1);

        // Queue a few tanks, then starve the water, the chemical line or both until a halt.
        send_beat(KIND_REQUEST, 4'd3, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                  1'($urandom));
        send_beat(KIND_REQUEST, 4'd7, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                  1'($urandom));
        send_beat(KIND_REQUEST, 4'd12, SAMPLE_BITS'($urandom), SAMPLE_BITS'($urandom),
                  1'($urandom));
        pick = $urandom_range(0, 2);
        for (int k = 0; k < 10; k++)
        begin
            low_val = SAMPLE_BITS'($urandom_range(0, thr_floor - 1));
            send_beat(KIND_TICK, TANK_BITS'($urandom),
                      (pick != 1) ? low_val : flow_sample(thr_floor, 1'b0),
                      (pick != 0) ? low_val : flow_sample(thr_floor, 1'b0), 1'($urandom));
        end
        drain();

        // Halted: requests still queue and the red lamp blinks at several half periods.
        blink_steps = '{32'd0, 32'd1, $urandom_range(2, 5), 32'hFFFF};
        foreach (blink_steps[j])
        begin
            write_reg({REG_BLINK_HALF, 2'b00}, blink_steps[j]);
            write_reg({REG_PUMP_DUTY, 2'b00}, $urandom);
            random_run(45, thr_floor, 1'b1);
        end

        drain();
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog on the whole run.
    initial
    begin
        #(SIM_LIMIT_NS);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
